### design/sps_pkg.sv
package sps_pkg;

  typedef enum logic [5:0] {
    ST_HDR       = 6'd0,
    ST_PROFILE   = 6'd1,
    ST_CONSTR    = 6'd2,
    ST_LEVEL     = 6'd3,
    ST_SPSID     = 6'd4,
    ST_CHROMA    = 6'd5,
    ST_RESID     = 6'd6,
    ST_BDL       = 6'd7,
    ST_BDC       = 6'd8,
    ST_BYPASS    = 6'd9,
    ST_SCALEFLAG = 6'd10,
    ST_SCALELIST = 6'd11,
    ST_LOG2FN    = 6'd12,
    ST_POCTYPE   = 6'd13,
    ST_POCLSB    = 6'd14,
    ST_DPOAZ     = 6'd15,
    ST_ONRP      = 6'd16,
    ST_OTTBF     = 6'd17,
    ST_NCYCLE    = 6'd18,
    ST_OFFREF    = 6'd19,
    ST_NREF      = 6'd20,
    ST_GAPS      = 6'd21,
    ST_WIDTH     = 6'd22,
    ST_HEIGHT    = 6'd23,
    ST_FMO       = 6'd24,
    ST_MBAFF     = 6'd25,
    ST_D8        = 6'd26,
    ST_CROPFLAG  = 6'd27,
    ST_CL        = 6'd28,
    ST_CR        = 6'd29,
    ST_CT        = 6'd30,
    ST_CB        = 6'd31,
    ST_VUI       = 6'd32,
    ST_ARFLAG    = 6'd33,
    ST_ARIDC     = 6'd34,
    ST_SAR       = 6'd35,
    ST_OVFLAG    = 6'd36,
    ST_OVAPP     = 6'd37,
    ST_VSFLAG    = 6'd38,
    ST_VSBITS    = 6'd39,
    ST_COLFLAG   = 6'd40,
    ST_COLBITS   = 6'd41,
    ST_CLFLAG    = 6'd42,
    ST_CLTOP     = 6'd43,
    ST_CLBOT     = 6'd44,
    ST_TIMFLAG   = 6'd45,
    ST_UNITS     = 6'd46,
    ST_SCALE     = 6'd47,
    ST_DONE      = 6'd48,
    ST_SKIP      = 6'd49
  } step_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_FEED = 2'd1,
    CTL_DIV  = 2'd2,
    CTL_OUT  = 2'd3
  } ctl_e;

  localparam logic [7:0] EMU_BYTE   = 8'h03;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [7:0] EXT_SAR    = 8'd255;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned DIV_STEPS = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;
    logic feed_bit;
    logic div_start;
    logic div_step;
    logic clear;
  } sps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;
  } sps_stat_t;

  // Width of a fixed-length field per syntax step; zero marks exp-Golomb.
  function automatic logic [5:0] fixed_bits(step_e s);
    logic [5:0] n;
    case (s)
      ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SCALELIST, ST_ARIDC: n = 6'd8;
      ST_RESID, ST_BYPASS, ST_SCALEFLAG, ST_DPOAZ, ST_GAPS, ST_FMO, ST_MBAFF,
      ST_D8, ST_CROPFLAG, ST_VUI, ST_ARFLAG, ST_OVFLAG, ST_OVAPP, ST_VSFLAG,
      ST_COLFLAG, ST_CLFLAG, ST_TIMFLAG: n = 6'd1;
      ST_VSBITS: n = 6'd4;
      ST_COLBITS: n = 6'd24;
      ST_SAR, ST_UNITS, ST_SCALE: n = 6'd32;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

### design/sps_ctrl.sv
module sps_ctrl
  import sps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      last_byte_i,
  input  logic      out_stall_i,
  input  sps_stat_t stat_i,
  output sps_cmd_t  cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  ctl_e       state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       accept;

  assign accept = (state_q == CTL_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          last_d = last_byte_i;
          cnt_d  = 6'(BYTE_BITS);
          if (!stat_i.drop) begin
            state_d = CTL_FEED;
          end else if (last_byte_i) begin
            state_d = CTL_DIV;
            cnt_d   = 6'(DIV_STEPS);
          end
        end
      end
      CTL_FEED: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          if (last_q) begin
            state_d = CTL_DIV;
            cnt_d   = 6'(DIV_STEPS);
          end else begin
            state_d = CTL_IDLE;
          end
        end
      end
      CTL_DIV: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = CTL_OUT;
        end
      end
      CTL_OUT: begin
        if (!out_stall_i) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_byte = accept;
        cmd_o.div_start = accept && stat_i.drop && last_byte_i;
      end
      CTL_FEED: begin
        cmd_o.feed_bit  = 1'b1;
        cmd_o.div_start = (cnt_q == 6'd1) && last_q;
      end
      CTL_DIV: cmd_o.div_step = 1'b1;
      CTL_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

endmodule

### design/sps_dpath.sv
module sps_dpath
  import sps_pkg::*;
#(
  parameter int unsigned MB_COUNT_LIMIT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sps_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output sps_stat_t   stat_o,
  output logic        is_sps_o,
  output logic [16:0] pic_width_o,
  output logic [16:0] pic_height_o,
  output logic [16:0] line_stride_o,
  output logic [31:0] frame_rate_o,
  output logic        rate_present_o,
  output logic        ran_short_o
);

  localparam int unsigned MBW = $clog2(MB_COUNT_LIMIT + 1);
  localparam int unsigned CSW = MBW + 1;
  localparam logic [32:0] LIMIT33 = 33'(MB_COUNT_LIMIT);
  localparam logic [31:0] CROP_MAX = 32'(MB_COUNT_LIMIT - 1);

  logic [1:0]     zrun_q, zrun_d;
  logic [7:0]     sh_q, sh_d;
  step_e          step_q, step_d;
  logic [5:0]     lz_q, lz_d;
  logic [31:0]    acc_q, acc_d;
  logic [5:0]     fbl_q, fbl_d;
  logic [31:0]    cc_q, cc_d;
  logic           hp_q, hp_d;
  logic [1:0]     poc_q, poc_d;
  logic [MBW-1:0] wmb_q, wmb_d;
  logic [MBW-1:0] hmb_q, hmb_d;
  logic [CSW-1:0] crop_q, crop_d;
  logic [31:0]    upt_q, upt_d;
  logic [31:0]    cks_q, cks_d;
  logic           nal_q, nal_d;

  logic [32:0]    rem_q, rem_d;
  logic [31:0]    quo_q, quo_d;
  logic [32:0]    dvs_q, dvs_d;

  logic           bit_in;
  logic [5:0]     fixed_w;
  logic           fld_done;
  logic [31:0]    value;
  logic [31:0]    acc_sh;
  logic [32:0]    v_inc;
  logic [MBW-1:0] v_sat;
  logic [31:0]    v_crop;
  logic [31:0]    cc_dec;
  step_e          nxt;
  logic [32:0]    rem_sh;

  assign stat_o.drop = (zrun_q == 2'd2) && (data_byte_i == EMU_BYTE);

  assign bit_in  = sh_q[7];
  assign fixed_w = fixed_bits(step_q);
  assign acc_sh  = {acc_q[30:0], bit_in};
  assign v_inc   = {1'b0, value} + 33'd1;
  assign v_sat   = (v_inc > LIMIT33) ? MBW'(MB_COUNT_LIMIT) : v_inc[MBW-1:0];
  assign v_crop  = (value > CROP_MAX) ? CROP_MAX : value;
  assign cc_dec  = cc_q - 32'd1;

  // Bit-serial parse of one syntax element per step.
  always_comb begin
    zrun_d   = zrun_q;
    sh_d     = sh_q;
    step_d   = step_q;
    lz_d     = lz_q;
    acc_d    = acc_q;
    fbl_d    = fbl_q;
    cc_d     = cc_q;
    hp_d     = hp_q;
    poc_d    = poc_q;
    wmb_d    = wmb_q;
    hmb_d    = hmb_q;
    crop_d   = crop_q;
    upt_d    = upt_q;
    cks_d    = cks_q;
    nal_d    = nal_q;
    fld_done = 1'b0;
    value    = '0;
    nxt      = step_q;

    if (cmd_i.load_byte) begin
      if (stat_o.drop) begin
        zrun_d = 2'd0;
      end else begin
        zrun_d = (data_byte_i == 8'd0) ? ((zrun_q == 2'd2) ? 2'd2 : zrun_q + 2'd1) : 2'd0;
        sh_d   = data_byte_i;
      end
    end

    if (cmd_i.feed_bit) begin
      sh_d = {sh_q[6:0], 1'b0};
      if (step_q < ST_DONE) begin
        if ((fixed_w == 6'd0) && (fbl_q == 6'd0)) begin
          if (!bit_in) begin
            if (lz_q != 6'd63) begin
              lz_d = lz_q + 6'd1;
            end
          end else if (lz_q != 6'd0) begin
            fbl_d = lz_q;
          end else begin
            fld_done = 1'b1;
          end
        end else begin
          acc_d = acc_sh;
          fbl_d = fbl_q - 6'd1;
          if (fbl_q == 6'd1) begin
            fld_done = 1'b1;
            if (fixed_w != 6'd0) begin
              value = acc_sh;
            end else if (lz_q >= 6'd32) begin
              value = '1;
            end else begin
              value = ((32'd1 << lz_q[4:0]) - 32'd1) + acc_sh;
            end
          end
        end
      end

      if (fld_done) begin
        case (step_q)
          ST_HDR: begin
            nal_d = (value[4:0] == NAL_SPS);
            nxt   = (value[4:0] == NAL_SPS) ? ST_PROFILE : ST_SKIP;
          end
          ST_PROFILE: begin
            hp_d = (value == 32'd100) || (value == 32'd110) ||
                   (value == 32'd122) || (value == 32'd144);
            nxt  = ST_CONSTR;
          end
          ST_SPSID:     nxt = hp_q ? ST_CHROMA : ST_LOG2FN;
          ST_CHROMA:    nxt = (value == 32'd3) ? ST_RESID : ST_BDL;
          ST_RESID:     nxt = ST_BDL;
          ST_SCALEFLAG: nxt = (value != 32'd0) ? ST_SCALELIST : ST_LOG2FN;
          ST_SCALELIST: nxt = ST_LOG2FN;
          ST_POCTYPE: begin
            if (value == 32'd0) begin
              poc_d = 2'd0;
              nxt   = ST_POCLSB;
            end else if (value == 32'd1) begin
              poc_d = 2'd1;
              nxt   = ST_DPOAZ;
            end else begin
              poc_d = 2'd2;
              nxt   = ST_NREF;
            end
          end
          ST_POCLSB: nxt = ST_NREF;
          ST_NCYCLE: begin
            cc_d = value;
            nxt  = (value != 32'd0) ? ST_OFFREF : ST_NREF;
          end
          ST_OFFREF: begin
            cc_d = cc_dec;
            nxt  = (cc_dec != 32'd0) ? ST_OFFREF : ST_NREF;
          end
          ST_WIDTH: begin
            wmb_d = v_sat;
            nxt   = ST_HEIGHT;
          end
          ST_HEIGHT: begin
            hmb_d = v_sat;
            nxt   = ST_FMO;
          end
          ST_FMO: nxt = (value != 32'd0) ? ST_D8 : ST_MBAFF;
          ST_CROPFLAG: begin
            crop_d = '0;
            nxt    = (value != 32'd0) ? ST_CL : ST_VUI;
          end
          ST_CL: begin
            crop_d = crop_q + CSW'(v_crop);
            nxt    = ST_CR;
          end
          ST_CR: begin
            crop_d = crop_q + CSW'(v_crop);
            nxt    = ST_CT;
          end
          ST_CB:      nxt = ST_VUI;
          ST_VUI:     nxt = (value != 32'd0) ? ST_ARFLAG : ST_DONE;
          ST_ARFLAG:  nxt = (value != 32'd0) ? ST_ARIDC : ST_OVFLAG;
          ST_ARIDC:   nxt = (value == 32'(EXT_SAR)) ? ST_SAR : ST_OVFLAG;
          ST_SAR:     nxt = ST_OVFLAG;
          ST_OVFLAG:  nxt = (value != 32'd0) ? ST_OVAPP : ST_VSFLAG;
          ST_OVAPP:   nxt = ST_VSFLAG;
          ST_VSFLAG:  nxt = (value != 32'd0) ? ST_VSBITS : ST_CLFLAG;
          ST_VSBITS:  nxt = ST_COLFLAG;
          ST_COLFLAG: nxt = (value != 32'd0) ? ST_COLBITS : ST_CLFLAG;
          ST_COLBITS: nxt = ST_CLFLAG;
          ST_CLFLAG:  nxt = (value != 32'd0) ? ST_CLTOP : ST_TIMFLAG;
          ST_CLBOT:   nxt = ST_TIMFLAG;
          ST_TIMFLAG: nxt = (value != 32'd0) ? ST_UNITS : ST_DONE;
          ST_UNITS: begin
            upt_d = value;
            nxt   = ST_SCALE;
          end
          ST_SCALE: begin
            cks_d = value;
            nxt   = ST_DONE;
          end
          default: nxt = step_e'(step_q + 6'd1);
        endcase
        step_d = nxt;
        lz_d   = '0;
        acc_d  = '0;
        fbl_d  = fixed_bits(nxt);
      end
    end

    if (cmd_i.clear) begin
      zrun_d = '0;
      sh_d   = '0;
      step_d = ST_HDR;
      lz_d   = '0;
      acc_d  = '0;
      fbl_d  = fixed_bits(ST_HDR);
      cc_d   = '0;
      hp_d   = 1'b0;
      poc_d  = '0;
      wmb_d  = '0;
      hmb_d  = '0;
      crop_d = '0;
      upt_d  = '0;
      cks_d  = '0;
      nal_d  = 1'b0;
    end
  end

  // Restoring divider: time scale over twice the tick units, one quotient bit a cycle.
  assign rem_sh = {rem_q[31:0], quo_q[31]};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = cks_d;
      dvs_d = {upt_d, 1'b0};
    end else if (cmd_i.div_step) begin
      if (rem_sh >= dvs_q) begin
        rem_d = rem_sh - dvs_q;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zrun_q <= '0;
      sh_q   <= '0;
      step_q <= ST_HDR;
      lz_q   <= '0;
      acc_q  <= '0;
      fbl_q  <= fixed_bits(ST_HDR);
      cc_q   <= '0;
      hp_q   <= 1'b0;
      poc_q  <= '0;
      wmb_q  <= '0;
      hmb_q  <= '0;
      crop_q <= '0;
      upt_q  <= '0;
      cks_q  <= '0;
      nal_q  <= 1'b0;
    end else begin
      zrun_q <= zrun_d;
      sh_q   <= sh_d;
      step_q <= step_d;
      lz_q   <= lz_d;
      acc_q  <= acc_d;
      fbl_q  <= fbl_d;
      cc_q   <= cc_d;
      hp_q   <= hp_d;
      poc_q  <= poc_d;
      wmb_q  <= wmb_d;
      hmb_q  <= hmb_d;
      crop_q <= crop_d;
      upt_q  <= upt_d;
      cks_q  <= cks_d;
      nal_q  <= nal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  logic [31:0] w32, h32, s32;
  logic        present;

  assign w32     = 32'(wmb_q) << 4;
  assign h32     = 32'(hmb_q) << 4;
  assign s32     = w32 + (32'(crop_q) << 1);
  assign present = nal_q && (step_q == ST_DONE) && (upt_q != 32'd0);

  assign is_sps_o       = nal_q;
  assign pic_width_o    = nal_q ? w32[16:0] : '0;
  assign pic_height_o   = nal_q ? h32[16:0] : '0;
  assign line_stride_o  = nal_q ? s32[16:0] : '0;
  assign frame_rate_o   = present ? quo_q : '0;
  assign rate_present_o = present;
  assign ran_short_o    = (step_q != ST_DONE) && (step_q != ST_SKIP);

endmodule

### design/h264_sps_geometry_parser_core.sv
// H.264 SPS geometry parser. Each input beat carries one raw byte of an SPS NAL
// unit, header byte first, with last_byte_i set on the final byte. Emulation
// prevention bytes (0x03 after two zero bytes) are dropped, and the remaining
// bits are decoded MSB first, one bit per clock, through the SPS syntax up to
// the VUI timing info. Each accepted byte is fed through the bit-serial parser
// before the next byte is taken; a dropped byte is accepted but not fed. After
// the last byte a restoring divider forms the frame rate (the timing clock rate
// over twice the tick unit count), and the single result beat is then held on
// the output until it is taken, after which the parser returns to its reset
// state. Macroblock counts saturate at MB_COUNT_LIMIT, and each crop offset at
// one less than that.
module h264_sps_geometry_parser_core
  import sps_pkg::*;
#(
  parameter int unsigned MB_COUNT_LIMIT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_sps_o,
  output logic [16:0] pic_width_o,
  output logic [16:0] pic_height_o,
  output logic [16:0] line_stride_o,
  output logic [31:0] frame_rate_o,
  output logic        rate_present_o,
  output logic        ran_short_o
);

  sps_cmd_t  cmd;
  sps_stat_t stat;

  // The controller sequences byte loads, bit feeding, division and output.
  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // The datapath holds the syntax state, the decoded fields and the divider.
  sps_dpath #(
    .MB_COUNT_LIMIT (MB_COUNT_LIMIT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_byte_i    (data_byte_i),
    .stat_o         (stat),
    .is_sps_o       (is_sps_o),
    .pic_width_o    (pic_width_o),
    .pic_height_o   (pic_height_o),
    .line_stride_o  (line_stride_o),
    .frame_rate_o   (frame_rate_o),
    .rate_present_o (rate_present_o),
    .ran_short_o    (ran_short_o)
  );

`ifndef ASSERT_OFF
  // While a result is waiting, no new byte may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("byte accepted while result pending");

  // A frame rate is only reported for a fully parsed unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rate_present_o) |-> (!ran_short_o && is_sps_o))
    else $error("rate reported for short or non-SPS unit");

  // A unit that is not an SPS reports no geometry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_sps_o) |-> (pic_width_o == 17'd0 && line_stride_o == 17'd0))
    else $error("geometry reported for non-SPS unit");
`endif

endmodule
